// ===== src/uvd_pkg.sv =====
// Shared types and constants for the LEB128 length-prefixed record deframer.
package uvd_pkg;

   localparam int unsigned DataWidth      = 8;
   localparam int unsigned LengthWidth    = 64;
   localparam int unsigned IndexWidth     = 4;
   localparam int unsigned ShiftWidth     = 6;
   localparam int unsigned GroupBits      = 7;
   localparam int unsigned MaxPrefixBytes = 10;

   localparam logic [IndexWidth-1:0] LastPrefixIndex = IndexWidth'(MaxPrefixBytes - 1);
   localparam logic [IndexWidth-1:0] PrefixLimit     = IndexWidth'(MaxPrefixBytes);

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_CORRUPT = 2'd2,
      KIND_TRUNC   = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 valid;
      logic [DataWidth-1:0] payload_byte;
      kind_type             kind;
      logic                 last_of_record;
   } result_type;

endpackage

// ===== src/uvd_step.sv =====
// Deframing state and the combinational step that turns one byte into at most one result.
module uvd_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [uvd_pkg::DataWidth-1:0] data_byte,
   input  logic                         end_of_buffer,
   output uvd_pkg::result_type          result
);
   import uvd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [LengthWidth-1:0] length_ff, length_in;
   logic [IndexWidth-1:0]  index_ff, index_in;
   logic [ShiftWidth-1:0]  shift;
   logic [LengthWidth-1:0] group_shifted;

   assign shift         = ShiftWidth'(index_ff) * ShiftWidth'(GroupBits);
   assign group_shifted = LengthWidth'(data_byte[GroupBits-1:0]) << shift;

   always_comb begin
      phase_in              = phase_ff;
      length_in             = length_ff;
      index_in              = index_ff;
      result.valid          = 1'b0;
      result.payload_byte   = '0;
      result.kind           = KIND_BYTE;
      result.last_of_record = 1'b0;
      case (phase_ff)
         PH_PREFIX: begin
            if (index_ff >= PrefixLimit) begin
               phase_in     = end_of_buffer ? PH_PREFIX : PH_DISCARD;
               length_in    = '0;
               index_in     = '0;
               result.valid = 1'b1;
               result.kind  = KIND_CORRUPT;
            end else if (!data_byte[DataWidth-1]) begin
               if (index_ff == LastPrefixIndex && data_byte > DataWidth'(1)) begin
                  phase_in     = end_of_buffer ? PH_PREFIX : PH_DISCARD;
                  length_in    = '0;
                  index_in     = '0;
                  result.valid = 1'b1;
                  result.kind  = KIND_CORRUPT;
               end else if (length_ff == '0 && data_byte == '0) begin
                  length_in             = '0;
                  index_in              = '0;
                  result.valid          = 1'b1;
                  result.kind           = KIND_EMPTY;
                  result.last_of_record = 1'b1;
               end else if (end_of_buffer) begin
                  length_in    = '0;
                  index_in     = '0;
                  result.valid = 1'b1;
                  result.kind  = KIND_TRUNC;
               end else begin
                  phase_in  = PH_PAYLOAD;
                  length_in = length_ff | group_shifted;
                  index_in  = '0;
               end
            end else if (end_of_buffer) begin
               length_in    = '0;
               index_in     = '0;
               result.valid = 1'b1;
               result.kind  = KIND_CORRUPT;
            end else begin
               length_in = length_ff | group_shifted;
               index_in  = index_ff + IndexWidth'(1);
            end
         end
         PH_PAYLOAD: begin
            if (length_ff == LengthWidth'(1)) begin
               phase_in              = PH_PREFIX;
               length_in             = '0;
               index_in              = '0;
               result.valid          = 1'b1;
               result.payload_byte   = data_byte;
               result.last_of_record = 1'b1;
            end else if (end_of_buffer) begin
               phase_in     = PH_PREFIX;
               length_in    = '0;
               index_in     = '0;
               result.valid = 1'b1;
               result.kind  = KIND_TRUNC;
            end else begin
               length_in           = length_ff - LengthWidth'(1);
               result.valid        = 1'b1;
               result.payload_byte = data_byte;
            end
         end
         default: begin
            if (end_of_buffer) begin
               phase_in  = PH_PREFIX;
               length_in = '0;
               index_in  = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         length_ff <= '0;
         index_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         index_ff  <= index_in;
      end
   end

endmodule

// ===== src/uvarint_length_prefix_deframer.sv =====
// Top level of the LEB128 length-prefixed record deframer.
//
// Bytes of a buffer arrive on the req_ channel, with req_end_of_buffer set on
// the final byte of each buffer. Each record is an unsigned LEB128 length
// prefix followed by that many payload bytes. Every input byte yields at most
// one transfer on the rsp_ channel: a payload byte, an empty-record mark, a
// corrupt-prefix status or a truncated-record status.
// A byte is registered on acceptance and processed by the step once it can
// advance; its result is presented from the output register. Throughput is
// one byte per cycle while rsp_stall is low, set by the single step that
// updates the length counter per byte.
// While rsp_stall is high the waiting result holds, and req_stall rises only
// once the input register holds a byte that cannot move on.
// Synchronous reset empties both registers and returns the parser to reading
// a fresh length prefix.
module uvarint_length_prefix_deframer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [uvd_pkg::DataWidth-1:0] req_data_byte,
   input  logic                          req_end_of_buffer,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [uvd_pkg::DataWidth-1:0] rsp_payload_byte,
   output logic [1:0]                    rsp_kind,
   output logic                          rsp_last_of_record
);
   import uvd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [DataWidth-1:0] in_data_ff;
   logic                 in_eob_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [DataWidth-1:0] out_byte_ff;
   kind_type             out_kind_ff;
   logic                 out_last_ff;
   logic                 advance;
   logic                 req_accept;
   result_type           result;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? result.valid : (out_valid_ff && rsp_stall);

   uvd_step u_step (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .data_byte     (in_data_ff),
      .end_of_buffer (in_eob_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data_byte;
         in_eob_ff  <= req_end_of_buffer;
      end
      if (advance && result.valid) begin
         out_byte_ff <= result.payload_byte;
         out_kind_ff <= result.kind;
         out_last_ff <= result.last_of_record;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_last_of_record = out_last_ff;

endmodule

// ===== verif/uvd_result_check.sv =====
// Checker for the deframer: predicts each result from the accepted bytes and compares it.
module uvd_result_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [uvd_pkg::DataWidth-1:0] req_data_byte,
   input  logic                          req_end_of_buffer,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [uvd_pkg::DataWidth-1:0] rsp_payload_byte,
   input  logic [1:0]                    rsp_kind,
   input  logic                          rsp_last_of_record,
   output int                            mismatch_count,
   output int                            pending_results
);
   import uvd_pkg::*;

   typedef struct packed {
      logic [DataWidth-1:0] payload_byte;
      kind_type             kind;
      logic                 last_of_record;
   } record_result_type;

   phase_type              parse_phase;
   logic [LengthWidth-1:0] length_acc;
   logic [IndexWidth-1:0]  prefix_idx;
   record_result_type      due_results[$];

   function automatic void restart_prefix();
      parse_phase = PH_PREFIX;
      length_acc  = '0;
      prefix_idx  = '0;
   endfunction

   function automatic bit deframe_byte(input logic [DataWidth-1:0] b, input logic eob,
                                       output record_result_type r);
      logic [LengthWidth-1:0] len;
      int                     sh;
      bit                     bad_prefix;
      r          = '{payload_byte: '0, kind: KIND_BYTE, last_of_record: 1'b0};
      bad_prefix = 1'b0;
      deframe_byte = 1'b0;
      case (parse_phase)
         PH_PREFIX: begin
            sh = GroupBits * int'(prefix_idx);
            if (prefix_idx >= PrefixLimit) begin
               bad_prefix = 1'b1;
            end else if (!b[7]) begin
               if (prefix_idx == LastPrefixIndex && b > 8'd1) begin
                  bad_prefix = 1'b1;
               end else begin
                  len = length_acc | (LengthWidth'(b) << sh);
                  if (len == '0) begin
                     restart_prefix();
                     r.kind           = KIND_EMPTY;
                     r.last_of_record = 1'b1;
                     deframe_byte     = 1'b1;
                  end else if (eob) begin
                     restart_prefix();
                     r.kind       = KIND_TRUNC;
                     deframe_byte = 1'b1;
                  end else begin
                     parse_phase = PH_PAYLOAD;
                     length_acc  = len;
                     prefix_idx  = '0;
                  end
               end
            end else begin
               length_acc = length_acc | (LengthWidth'(b[6:0]) << sh);
               prefix_idx = prefix_idx + 1'b1;
               if (eob) begin
                  bad_prefix = 1'b1;
               end
            end
            if (bad_prefix) begin
               restart_prefix();
               if (!eob) begin
                  parse_phase = PH_DISCARD;
               end
               r.kind       = KIND_CORRUPT;
               deframe_byte = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            len = length_acc - 1'b1;
            if (len == '0) begin
               restart_prefix();
               r.payload_byte   = b;
               r.last_of_record = 1'b1;
            end else if (eob) begin
               restart_prefix();
               r.kind = KIND_TRUNC;
            end else begin
               length_acc     = len;
               r.payload_byte = b;
            end
            deframe_byte = 1'b1;
         end
         default: begin
            if (eob) begin
               restart_prefix();
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : track
      record_result_type fresh;
      record_result_type due;
      if (reset) begin
         restart_prefix();
         due_results.delete();
         mismatch_count  = 0;
         pending_results = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (deframe_byte(req_data_byte, req_end_of_buffer, fresh)) begin
               due_results.insert(due_results.size(), fresh);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("unexpected transfer: payload_byte %0h, kind %0d, last_of_record %0b",
                      rsp_payload_byte, rsp_kind, rsp_last_of_record);
               mismatch_count++;
            end else begin
               due = due_results.pop_front();
               if (rsp_payload_byte !== due.payload_byte) begin
                  $error("payload_byte: expected %0h, actual %0h",
                         due.payload_byte, rsp_payload_byte);
                  mismatch_count++;
               end
               if (rsp_kind !== due.kind) begin
                  $error("kind: expected %0d, actual %0d", due.kind, rsp_kind);
                  mismatch_count++;
               end
               if (rsp_last_of_record !== due.last_of_record) begin
                  $error("last_of_record: expected %0b, actual %0b",
                         due.last_of_record, rsp_last_of_record);
                  mismatch_count++;
               end
            end
         end
         pending_results = due_results.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus, receiver stalls and verdict.
module tb;
   import uvd_pkg::*;

   localparam int StallNone     = 0;
   localparam int StallLight    = 1;
   localparam int StallHeavy    = 2;
   localparam int StallLong     = 3;
   localparam int WatchdogLimit = 1000;
   localparam int ItemTarget    = 1050;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [DataWidth-1:0] req_data_byte;
   logic                 req_end_of_buffer;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [DataWidth-1:0] rsp_payload_byte;
   logic [1:0]           rsp_kind;
   logic                 rsp_last_of_record;
   int                   mismatch_count;
   int                   pending_results;

   int                   stall_mode;
   int                   stall_left;
   int                   burst_left;
   bit                   steady;
   int                   idle_cycles;
   int                   sent_items;
   logic [7:0]           frame_q[$];

   uvarint_length_prefix_deframer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_kind           (rsp_kind),
      .rsp_last_of_record (rsp_last_of_record)
   );

   uvd_result_check u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_end_of_buffer  (req_end_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_kind           (rsp_kind),
      .rsp_last_of_record (rsp_last_of_record),
      .mismatch_count     (mismatch_count),
      .pending_results    (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         case (stall_mode)
            StallNone: begin
               rsp_stall <= 1'b0;
            end
            StallLight: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            StallHeavy: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               if (stall_left != 0) begin
                  rsp_stall  <= 1'b1;
                  stall_left <= stall_left - 1;
               end else begin
                  rsp_stall <= 1'b0;
                  if ($urandom_range(0, 9) == 0) begin
                     stall_left <= $urandom_range(5, 30);
                  end
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("[uvarint_length_prefix_deframer] ERROR");
            $finish;
         end
      end
   end

   function automatic void queue_byte(input logic [7:0] b);
      frame_q.insert(frame_q.size(), b);
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic eob);
      int gap;
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_buffer <= eob;
      do @(posedge clock); while (req_stall);
      sent_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = steady ? 0 : $urandom_range(0, 6);
         burst_left = steady ? 60 : $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_frame();
      foreach (frame_q[i]) begin
         push_byte(frame_q[i], i == frame_q.size() - 1);
      end
      frame_q.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      @(posedge clock);
   endtask

   task automatic add_record(input bit may_break);
      int               len;
      int               pad;
      int               sel;
      logic [63:0]      v;
      logic [6:0]       grp;
      sel = may_break ? $urandom_range(0, 99) : $urandom_range(20, 99);
      if (sel < 12) begin
         repeat (9) queue_byte(8'h80 | 8'($urandom_range(0, 127)));
         queue_byte(8'($urandom_range(0, 255)));
         if (frame_q[$][7]) begin
            queue_byte(8'($urandom_range(0, 255)));
         end
         return;
      end
      if (sel < 20) begin
         repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
         return;
      end
      len = (sel < 23) ? $urandom_range(128, 260) : $urandom_range(0, 6);
      pad = 0;
      if ($urandom_range(0, 4) == 0) begin
         pad = $urandom_range(1, (may_break || len < 128) ? 9 : 8);
      end
      v = 64'(len);
      do begin
         grp = v[6:0];
         v   = v >> 7;
         queue_byte({(v != 0 || pad != 0), grp});
      end while (v != 0);
      if (pad != 0) begin
         repeat (pad - 1) queue_byte(8'h80);
         queue_byte(8'h00);
      end
      repeat (len) queue_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int nrec;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_end_of_buffer = 1'b0;
      stall_mode        = StallNone;
      burst_left        = 0;
      steady            = 1'b0;
      sent_items        = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      frame_q = {8'h00};
      send_frame();
      frame_q = {8'h02, 8'h00, 8'hff};
      send_frame();
      frame_q = {8'h05};
      send_frame();
      frame_q = {8'h02, 8'h11};
      send_frame();
      frame_q = {8'h80};
      send_frame();
      repeat (9) queue_byte(8'h80);
      queue_byte(8'h02);
      queue_byte(8'hff);
      send_frame();
      repeat (9) queue_byte(8'hff);
      queue_byte(8'h81);
      queue_byte(8'h00);
      send_frame();
      drain();

      sent_items = 0;
      while (sent_items < ItemTarget) begin
         if ($urandom_range(0, 5) == 0) begin
            stall_mode <= $urandom_range(StallNone, StallLong);
         end
         if ($urandom_range(0, 7) == 0) begin
            steady = !steady;
         end
         nrec = $urandom_range(1, 3);
         for (int r = 0; r < nrec; r++) begin
            add_record(r == nrec - 1);
         end
         if (frame_q.size() > 1 && $urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
         end
         send_frame();
         if ($urandom_range(0, 19) == 0) begin
            drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[uvarint_length_prefix_deframer] OK");
      end else begin
         $display("[uvarint_length_prefix_deframer] ERROR");
      end
      $finish;
   end

endmodule
